// ===== src/rpm_pkg.sv =====
package rpm_pkg;

  // window and derived widths
  localparam int WINDOW  = 200;
  localparam int RING_AW = (WINDOW > 2) ? $clog2(WINDOW) : 1;
  localparam int SQ_W    = 31;
  localparam int SUM_W   = SQ_W + $clog2(WINDOW);
  localparam int SCL_W   = 32 + $clog2(WINDOW);
  localparam int INT_W   = 40;
  localparam int PI_W    = 42;

  localparam logic [15:0]      THIRD_TURN = 16'd21845;
  localparam logic [SCL_W-1:0] WIN_SCALE  = SCL_W'(WINDOW);
  // ceil(2^28 / 15): exact floor division by 15 for any 24-bit operand
  localparam logic [24:0]      RECIP_15   = 25'd17895698;
  localparam logic signed [INT_W:0] INT_MAX = 41'sd549755813887;
  localparam logic signed [INT_W:0] INT_MIN = -41'sd549755813888;

  // register indexes
  typedef enum logic [1:0] {
    CFG_TARGET  = 2'd0,
    CFG_KP_GAIN = 2'd1,
    CFG_KI_GAIN = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    F_CLEAR,
    F_IDLE,
    F_UPD
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQA,
    B_SQB,
    B_MUL,
    B_PI,
    B_MLO,
    B_MHI,
    B_DIVM,
    B_SAT,
    B_INT,
    B_DONE
  } back_state_t;

  // one queued beat: window sum after the update and the angle
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [15:0]      angle;
  } rpm_item_t;

  localparam logic [14:0] SINE_Q [65] = '{
    15'd0, 15'd804, 15'd1608, 15'd2410, 15'd3212, 15'd4011, 15'd4808, 15'd5602,
    15'd6393, 15'd7179, 15'd7962, 15'd8739, 15'd9512, 15'd10278, 15'd11039, 15'd11793,
    15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846,
    15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403,
    15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329,
    15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683, 15'd28105, 15'd28510,
    15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273, 15'd30571, 15'd30852,
    15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971, 15'd32137, 15'd32285,
    15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757, 15'd32767
  };

  // quarter-wave sine lookup, Q1.15
  function automatic logic signed [15:0] table_sine(input logic [15:0] angle);
    logic [7:0]  idx;
    logic [6:0]  k;
    logic [14:0] s;
    idx = angle[15:8];
    k   = {1'b0, idx[5:0]};
    s   = idx[6] ? SINE_Q[7'd64 - k] : SINE_Q[k];
    return idx[7] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

endpackage

// ===== src/rpm_if.sv =====
interface rpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_va;
  logic        [15:0] phase_angle;
  modport source(output valid, sample_va, phase_angle, input ready);
  modport sink(input valid, sample_va, phase_angle, output ready);
endinterface

interface rpm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mod_a;
  logic signed [15:0] mod_b;
  logic signed [15:0] mod_c;
  logic        [15:0] rms_level;
  logic               clipped;
  modport source(output valid, mod_a, mod_b, mod_c, rms_level, clipped, input ready);
  modport sink(input valid, mod_a, mod_b, mod_c, rms_level, clipped, output ready);
endinterface

// ===== src/rpm_front.sv =====
module rpm_front (
  input  logic              clk,
  input  logic              rst_n,
  rpm_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              push_valid,
  output rpm_pkg::rpm_item_t push_item
);

  rpm_pkg::front_state_t state_r, state_nxt;

  logic [rpm_pkg::SQ_W-1:0]    ring_mem [rpm_pkg::WINDOW];
  logic [rpm_pkg::SQ_W-1:0]    rd_r;
  logic [rpm_pkg::SQ_W-1:0]    sq_r;
  logic [15:0]                 angle_r;
  logic [rpm_pkg::RING_AW-1:0] pos_r, clr_r;
  logic [rpm_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [31:0]          sq_full;
  logic                        accept;
  logic                        mem_we;
  logic [rpm_pkg::RING_AW-1:0] mem_wa;
  logic [rpm_pkg::SQ_W-1:0]    mem_wd;

  assign accept  = in_ch.valid && in_ch.ready;
  assign sq_full = in_ch.sample_va * in_ch.sample_va;
  assign sum_nxt = sum_r - rpm_pkg::SUM_W'(rd_r) + rpm_pkg::SUM_W'(sq_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpm_pkg::F_CLEAR: begin
        if (clr_r == rpm_pkg::RING_AW'(rpm_pkg::WINDOW - 1)) state_nxt = rpm_pkg::F_IDLE;
      end
      rpm_pkg::F_IDLE: begin
        if (accept) state_nxt = rpm_pkg::F_UPD;
      end
      rpm_pkg::F_UPD:  state_nxt = rpm_pkg::F_IDLE;
      default:         state_nxt = rpm_pkg::F_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = pos_r;
    mem_wd      = sq_r;
    case (state_r)
      rpm_pkg::F_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      rpm_pkg::F_IDLE:  in_ch.ready = !q_full;
      rpm_pkg::F_UPD: begin
        mem_we     = 1'b1;
        push_valid = 1'b1;
      end
      default: ;
    endcase
  end

  assign push_item.sum   = sum_nxt;
  assign push_item.angle = angle_r;

  // square ring
  always_ff @(posedge clk) begin
    if (mem_we) ring_mem[mem_wa] <= mem_wd;
    rd_r <= ring_mem[pos_r];
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r    <= rpm_pkg::SQ_W'(unsigned'(sq_full));
      angle_r <= in_ch.phase_angle;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpm_pkg::F_CLEAR;
      clr_r   <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rpm_pkg::F_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == rpm_pkg::F_UPD) begin
        sum_r <= sum_nxt;
        pos_r <= (pos_r == rpm_pkg::RING_AW'(rpm_pkg::WINDOW - 1)) ? '0 : pos_r + 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rpm_pkg::F_CLEAR |-> !in_ch.ready) else $error("accept during clear");
  a_push_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> $past(accept)) else $error("push without accepted beat");
`endif

endmodule

// ===== src/rpm_queue.sv =====
module rpm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rpm_pkg::rpm_item_t push_item,
  output logic               full,
  input  logic               pop,
  output rpm_pkg::rpm_item_t pop_item,
  output logic               avail
);

  rpm_pkg::rpm_item_t slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign avail    = (cnt_r != 2'd0);
  assign pop_item = slot_r[rd_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_item;
  end

  // pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> avail) else $error("queue underflow");
`endif

endmodule

// ===== src/rpm_back.sv =====
module rpm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               avail,
  input  rpm_pkg::rpm_item_t pop_item,
  output logic               pop,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  rpm_out_if.source          out_ch
);

  rpm_pkg::back_state_t state_r, state_nxt;

  logic [14:0] target_r;
  logic [15:0] kp_r, ki_r;

  logic [rpm_pkg::SUM_W-1:0] sum_r;
  logic [15:0] res_r, bit_r, trial;
  logic [31:0] sq_r;
  logic [rpm_pkg::SCL_W-1:0] scaled;
  logic        fits;

  logic [15:0] rms_r;
  logic [15:0] angle_r;
  logic signed [16:0] err;
  logic signed [33:0] kp_err_r, ki_err_r;
  logic signed [rpm_pkg::PI_W-1:0] pi_r;
  logic [rpm_pkg::PI_W-1:0] pi_mag;
  logic signed [rpm_pkg::INT_W-1:0] integ_r;
  logic signed [rpm_pkg::INT_W:0]   integ_nxt;
  logic        int_sat;

  logic [1:0]  ph_r;
  logic [15:0] ph_angle;
  logic signed [15:0] sine;
  logic [14:0] as_r;
  logic        s_neg_r;
  logic [35:0] plo_r;
  logic [57:0] prod;
  logic [24:0] t_r;
  logic [48:0] qprod;
  logic [20:0] q_r;
  logic        neg;
  logic signed [15:0] mod_val;
  logic        mod_sat;
  logic signed [15:0] mod_r [3];
  logic        clip_r;
  logic        out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      kp_r     <= 16'd256;
      ki_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rpm_pkg::CFG_TARGET:  target_r <= cfg_data[14:0];
        rpm_pkg::CFG_KP_GAIN: kp_r     <= cfg_data;
        rpm_pkg::CFG_KI_GAIN: ki_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // root search: largest r with WINDOW * r * r not above the sum
  assign trial  = res_r | bit_r;
  assign scaled = rpm_pkg::SCL_W'(sq_r) * rpm_pkg::WIN_SCALE;
  assign fits   = (scaled <= rpm_pkg::SCL_W'(sum_r));

  // loop error
  assign err = $signed({2'b00, target_r}) - $signed({1'b0, res_r});

  // phase angle and sine
  always_comb begin
    case (ph_r)
      2'd1:    ph_angle = angle_r - rpm_pkg::THIRD_TURN;
      2'd2:    ph_angle = angle_r + rpm_pkg::THIRD_TURN;
      default: ph_angle = angle_r;
    endcase
  end
  assign sine   = rpm_pkg::table_sine(ph_angle);
  assign pi_mag = pi_r[rpm_pkg::PI_W-1] ? unsigned'(-pi_r) : unsigned'(pi_r);
  assign prod   = {22'd0, 36'(pi_mag[41:21] * as_r)} << 21;

  // divide by 30: halve, then multiply by the reciprocal of 15
  assign qprod = t_r[24:1] * rpm_pkg::RECIP_15;

  // sign and saturation of one phase
  assign neg = pi_r[rpm_pkg::PI_W-1] ^ s_neg_r;
  always_comb begin
    mod_sat = 1'b0;
    if (neg) begin
      if (q_r > 21'd32768) begin
        mod_val = -16'sd32768;
        mod_sat = 1'b1;
      end else begin
        mod_val = -$signed(q_r[15:0]);
      end
    end else begin
      if (q_r > 21'd32767) begin
        mod_val = 16'sd32767;
        mod_sat = 1'b1;
      end else begin
        mod_val = $signed(q_r[15:0]);
      end
    end
  end

  assign integ_nxt = $signed({integ_r[rpm_pkg::INT_W-1], integ_r})
                   + $signed({{7{ki_err_r[33]}}, ki_err_r});
  assign int_sat   = (integ_nxt > rpm_pkg::INT_MAX) || (integ_nxt < rpm_pkg::INT_MIN);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpm_pkg::B_IDLE: if (avail) state_nxt = rpm_pkg::B_SQA;
      rpm_pkg::B_SQA:  state_nxt = rpm_pkg::B_SQB;
      rpm_pkg::B_SQB:  state_nxt = (bit_r == 16'd1) ? rpm_pkg::B_MUL : rpm_pkg::B_SQA;
      rpm_pkg::B_MUL:  state_nxt = rpm_pkg::B_PI;
      rpm_pkg::B_PI:   state_nxt = rpm_pkg::B_MLO;
      rpm_pkg::B_MLO:  state_nxt = rpm_pkg::B_MHI;
      rpm_pkg::B_MHI:  state_nxt = rpm_pkg::B_DIVM;
      rpm_pkg::B_DIVM: state_nxt = rpm_pkg::B_SAT;
      rpm_pkg::B_SAT:  state_nxt = (ph_r == 2'd2) ? rpm_pkg::B_INT : rpm_pkg::B_MLO;
      rpm_pkg::B_INT:  state_nxt = rpm_pkg::B_DONE;
      rpm_pkg::B_DONE: if (!out_valid_r || out_ch.ready) state_nxt = rpm_pkg::B_IDLE;
      default:         state_nxt = rpm_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop = 1'b0;
    case (state_r)
      rpm_pkg::B_IDLE: pop = avail;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      rpm_pkg::B_IDLE: begin
        sum_r   <= pop_item.sum;
        angle_r <= pop_item.angle;
        res_r   <= '0;
        bit_r   <= 16'h8000;
        ph_r    <= 2'd0;
        clip_r  <= 1'b0;
      end
      rpm_pkg::B_SQA: begin
        sq_r <= trial * trial;
      end
      rpm_pkg::B_SQB: begin
        if (fits) res_r <= trial;
        bit_r <= bit_r >> 1;
      end
      rpm_pkg::B_MUL: begin
        rms_r    <= res_r;
        kp_err_r <= $signed({1'b0, kp_r}) * err;
        ki_err_r <= $signed({1'b0, ki_r}) * err;
      end
      rpm_pkg::B_PI: begin
        pi_r <= $signed({kp_err_r, 8'd0})
              + $signed({{2{integ_r[rpm_pkg::INT_W-1]}}, integ_r});
      end
      rpm_pkg::B_MLO: begin
        s_neg_r <= sine[15];
        as_r    <= sine[15] ? 15'(unsigned'(-sine)) : sine[14:0];
        plo_r   <= pi_mag[20:0] * (sine[15] ? 15'(unsigned'(-sine)) : sine[14:0]);
      end
      rpm_pkg::B_MHI: begin
        t_r <= 25'((prod + 58'(plo_r)) >> 31);
      end
      rpm_pkg::B_DIVM: begin
        q_r <= qprod[48:28];
      end
      rpm_pkg::B_SAT: begin
        mod_r[ph_r] <= mod_val;
        clip_r      <= clip_r | mod_sat;
        ph_r        <= ph_r + 1'b1;
      end
      rpm_pkg::B_INT: begin
        clip_r <= clip_r | int_sat;
      end
      default: ;
    endcase
  end

  // integrator and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpm_pkg::B_IDLE;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rpm_pkg::B_INT) begin
        if (integ_nxt > rpm_pkg::INT_MAX) begin
          integ_r <= rpm_pkg::INT_MAX[rpm_pkg::INT_W-1:0];
        end else if (integ_nxt < rpm_pkg::INT_MIN) begin
          integ_r <= rpm_pkg::INT_MIN[rpm_pkg::INT_W-1:0];
        end else begin
          integ_r <= integ_nxt[rpm_pkg::INT_W-1:0];
        end
      end
      if (state_r == rpm_pkg::B_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == rpm_pkg::B_DONE && (!out_valid_r || out_ch.ready)) begin
      out_ch.mod_a     <= mod_r[0];
      out_ch.mod_b     <= mod_r[1];
      out_ch.mod_c     <= mod_r[2];
      out_ch.rms_level <= rms_r;
      out_ch.clipped   <= clip_r;
    end
  end

  assign out_ch.valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_rms_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.rms_level <= 16'd32768) else $error("rms out of range");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == rpm_pkg::B_SQA) else $error("pop outside idle");
`endif

endmodule

// ===== src/rms_pi_three_phase_modulator_unit.sv =====
// Sliding-window RMS voltage loop with a three-phase sine modulator. Each input beat
// squares the phase-A sample into a 200-entry ring and updates a running sum; the back
// end finds the RMS as the largest r with 200 * r * r not above the sum, runs a PI
// controller on the target minus the RMS and scales the table sines of the angle and of
// the angle -/+ 120 degrees, dividing by 30 and saturating. The front takes no new beat
// while it writes back the last one, and takes one only while the two-entry queue has
// room. The back pops a new beat only from idle, so it first finishes the last one: a
// 16-bit root search with two states per bit, then three phase scalings of four states
// each. After reset the ring is cleared in one pass, during which no input beat is accepted.
module rms_pi_three_phase_modulator_unit (
  input  logic        clk,
  input  logic        rst_n,
  rpm_in_if.sink      in_ch,
  rpm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rpm_pkg::rpm_item_t push_item, pop_item;
  logic push_valid, q_full, pop, avail;

  rpm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  rpm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .avail     (avail)
  );

  rpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (avail),
    .pop_item  (pop_item),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule
